>>> hdl/tile_matrix_multiply_accumulate_top_assert.svh
// assertion macros for the tile multiply-accumulate block
`ifndef TILE_MATRIX_MULTIPLY_ACCUMULATE_TOP_ASSERT_SVH
`define TILE_MATRIX_MULTIPLY_ACCUMULATE_TOP_ASSERT_SVH

// same-cycle implication
`define TMMA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmma check failed");

// next-cycle implication
`define TMMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmma check failed");

`endif

>>> hdl/tmma_pkg.sv
package tmma_pkg;

    localparam int TILE_DEF          = 8;
    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int ACC_WIDTH_DEF     = 40;
    localparam int QUEUE_DEPTH       = 2;

    typedef enum logic [1:0] {
        MODE_LOAD_B  = 2'd0,
        MODE_ACC     = 2'd1,
        MODE_READ    = 2'd2,
        MODE_PRELOAD = 2'd3
    } t_mode;

endpackage

>>> hdl/tmma_in_if.sv
interface tmma_in_if #(
    parameter int IDX_W = $clog2(tmma_pkg::TILE_DEF),
    parameter int OP_W  = tmma_pkg::OPERAND_WIDTH_DEF,
    parameter int ACC_W = tmma_pkg::ACC_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic [1:0]              mode;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [OP_W-1:0]  operand;
    logic signed [ACC_W-1:0] acc_in;

    modport source (output valid, mode, row, col, operand, acc_in, input ready);
    modport sink   (input valid, mode, row, col, operand, acc_in, output ready);
endinterface

>>> hdl/tmma_out_if.sv
interface tmma_out_if #(
    parameter int IDX_W = $clog2(tmma_pkg::TILE_DEF),
    parameter int ACC_W = tmma_pkg::ACC_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [ACC_W-1:0] sum;
    logic                    last;

    modport source (output valid, out_row, out_col, sum, last, input ready);
    modport sink   (input valid, out_row, out_col, sum, last, output ready);
endinterface

>>> hdl/tile_matrix_multiply_accumulate_top.sv
// channel  | dir | modport | payload
// ---------+-----+---------+---------------------------------
// i_in     | in  | sink    | mode, row, col, operand, acc_in
// o_out    | out | source  | out_row, out_col, sum, last
//
// load B and preload are done as they leave the queue in the execution side, accumulate
// runs as bank read, 8 multipliers, then saturating add and write back; readout reads the
// bank, then gives one result per cycle while o_out is ready: 8 results for a full row.
// a 2-entry command queue lets i_in keep accepting while the execution side works.
// reset clears the accumulator valid bits at once, no clearing pass is needed.
// a stalled o_out holds the readout and, once the queue fills, i_in.ready drops.
`include "tile_matrix_multiply_accumulate_top_assert.svh"

module tile_matrix_multiply_accumulate_top #(
    parameter int TILE          = tmma_pkg::TILE_DEF,
    parameter int OPERAND_WIDTH = tmma_pkg::OPERAND_WIDTH_DEF,
    parameter int ACC_WIDTH     = tmma_pkg::ACC_WIDTH_DEF,
    localparam int IDX_W        = $clog2(TILE),
    localparam int CMD_W        = 2 + 2 * IDX_W + OPERAND_WIDTH + ACC_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tmma_in_if.sink    i_in,
    tmma_out_if.source o_out
);
    import tmma_pkg::*;

    logic             q_push, q_pop, q_full, q_empty;
    logic [CMD_W-1:0] q_wdata, q_rdata;

    tmma_front #(
        .TILE  (TILE),
        .OP_W  (OPERAND_WIDTH),
        .ACC_W (ACC_WIDTH)
    ) u_front (
        .i_in   (i_in),
        .i_full (q_full),
        .o_push (q_push),
        .o_cmd  (q_wdata)
    );

    tmma_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    tmma_back #(
        .TILE  (TILE),
        .OP_W  (OPERAND_WIDTH),
        .ACC_W (ACC_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (q_rdata),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

    `TMMA_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, q_pop, !q_empty)
    `TMMA_ASSERT_IMPL(a_push_room, i_clk, i_rst_n, q_push, !q_full && i_in.valid)
    `TMMA_ASSERT_IMPL(a_last_col, i_clk, i_rst_n, o_out.valid && o_out.last, o_out.out_col == IDX_W'(TILE - 1))
    `TMMA_ASSERT_NEXT(a_full_holds, i_clk, i_rst_n, q_full && !q_pop, q_full)
endmodule

>>> hdl/tmma_ram.sv
module tmma_ram #(
    parameter int WIDTH = tmma_pkg::OPERAND_WIDTH_DEF,
    parameter int DEPTH = tmma_pkg::TILE_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/tmma_queue.sv
module tmma_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tmma_pkg::QUEUE_DEPTH,
    localparam int PW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
endmodule

>>> hdl/tmma_front.sv
module tmma_front #(
    parameter int TILE  = tmma_pkg::TILE_DEF,
    parameter int OP_W  = tmma_pkg::OPERAND_WIDTH_DEF,
    parameter int ACC_W = tmma_pkg::ACC_WIDTH_DEF,
    localparam int IDX_W = $clog2(TILE),
    localparam int CMD_W = 2 + 2 * IDX_W + OP_W + ACC_W
) (
    tmma_in_if.sink          i_in,
    input  logic             i_full,
    output logic             o_push,
    output logic [CMD_W-1:0] o_cmd
);
    import tmma_pkg::*;

    typedef struct packed {
        t_mode            mode;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [OP_W-1:0]  operand;
        logic [ACC_W-1:0] acc_in;
    } t_cmd;

    t_cmd cmd;
    logic row_ok, col_ok;

    always_comb begin
        cmd.mode    = t_mode'(i_in.mode);
        cmd.row     = i_in.row;
        cmd.col     = i_in.col;
        cmd.operand = i_in.operand;
        cmd.acc_in  = i_in.acc_in;
    end

    // out-of-tile indexes are dropped here, readout ignores col
    assign row_ok = ({1'b0, i_in.row} < (IDX_W + 1)'(TILE));
    assign col_ok = (cmd.mode == MODE_READ) || ({1'b0, i_in.col} < (IDX_W + 1)'(TILE));

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full && row_ok && col_ok;
    assign o_cmd      = cmd;
endmodule

>>> hdl/tmma_back.sv
module tmma_back #(
    parameter int TILE  = tmma_pkg::TILE_DEF,
    parameter int OP_W  = tmma_pkg::OPERAND_WIDTH_DEF,
    parameter int ACC_W = tmma_pkg::ACC_WIDTH_DEF,
    localparam int IDX_W = $clog2(TILE),
    localparam int CMD_W = 2 + 2 * IDX_W + OP_W + ACC_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CMD_W-1:0] i_cmd,
    input  logic             i_empty,
    output logic             o_pop,
    tmma_out_if.source       o_out
);
    import tmma_pkg::*;

    localparam int PROD_W = 2 * OP_W;
    localparam int SUM_W  = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 1;
    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W - 1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W - 1){1'b0}}};

    typedef struct packed {
        t_mode            mode;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [OP_W-1:0]  operand;
        logic [ACC_W-1:0] acc_in;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_ADD  = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [PROD_W-1:0] p);
        logic [SUM_W-1:0]     s;
        logic [SUM_W-ACC_W:0] hi;
        s  = {{(SUM_W - ACC_W){a[ACC_W-1]}}, a} + {{(SUM_W - PROD_W){p[PROD_W-1]}}, p};
        hi = s[SUM_W-1:ACC_W-1];
        if (hi == '0 || hi == '1) begin
            return s[ACC_W-1:0];
        end else if (s[SUM_W-1]) begin
            return ACC_MIN;
        end else begin
            return ACC_MAX;
        end
    endfunction

    t_cmd                    cmd;
    t_state                  r_state, n_state;
    logic [IDX_W-1:0]        r_row, n_row, r_cnt, n_cnt;
    logic signed [OP_W-1:0]  r_a;
    logic signed [PROD_W-1:0] r_prod [TILE];
    logic [TILE-1:0][TILE-1:0] r_vld;
    logic [TILE-1:0]         b_we, acc_we;
    logic                    b_re, acc_re, out_load;
    logic [IDX_W-1:0]        acc_waddr;
    logic [OP_W-1:0]         b_rdata [TILE];
    logic [ACC_W-1:0]        acc_rdata [TILE];
    logic [ACC_W-1:0]        acc_val [TILE];
    logic [ACC_W-1:0]        acc_wdata [TILE];

    logic                    r_out_valid;
    logic [IDX_W-1:0]        r_out_row, r_out_col;
    logic [ACC_W-1:0]        r_out_sum;
    logic                    r_out_last;

    assign cmd = i_cmd;

    for (genvar j = 0; j < TILE; j++) begin : g_lane
        tmma_ram #(.WIDTH(OP_W), .DEPTH(TILE)) u_b_ram (
            .i_clk   (i_clk),
            .i_we    (b_we[j]),
            .i_waddr (cmd.row),
            .i_wdata (cmd.operand),
            .i_re    (b_re),
            .i_raddr (cmd.col),
            .o_rdata (b_rdata[j])
        );

        tmma_ram #(.WIDTH(ACC_W), .DEPTH(TILE)) u_acc_ram (
            .i_clk   (i_clk),
            .i_we    (acc_we[j]),
            .i_waddr (acc_waddr),
            .i_wdata (acc_wdata[j]),
            .i_re    (acc_re),
            .i_raddr (cmd.row),
            .o_rdata (acc_rdata[j])
        );

        // never-written accumulators read as zero
        assign acc_val[j]   = r_vld[r_row][j] ? acc_rdata[j] : '0;
        assign acc_wdata[j] = (r_state == ST_ADD) ? sat_add(acc_val[j], r_prod[j])
                                                  : cmd.acc_in;

        always_ff @(posedge i_clk) begin
            if (r_state == ST_MUL) begin
                r_prod[j] <= r_a * $signed(b_rdata[j]);
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_cnt     = r_cnt;
        o_pop     = 1'b0;
        b_we      = '0;
        acc_we    = '0;
        b_re      = 1'b0;
        acc_re    = 1'b0;
        acc_waddr = cmd.row;
        out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_row = cmd.row;
                    unique case (cmd.mode)
                        MODE_LOAD_B: begin
                            b_we[cmd.col] = 1'b1;
                        end
                        MODE_ACC: begin
                            b_re    = 1'b1;
                            acc_re  = 1'b1;
                            n_state = ST_MUL;
                        end
                        MODE_READ: begin
                            acc_re  = 1'b1;
                            n_cnt   = '0;
                            n_state = ST_OUT;
                        end
                        MODE_PRELOAD: begin
                            acc_we[cmd.col] = 1'b1;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                n_state = ST_ADD;
            end
            ST_ADD: begin
                acc_we    = '1;
                acc_waddr = r_row;
                n_state   = ST_IDLE;
            end
            ST_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    if (r_cnt == IDX_W'(TILE - 1)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row       <= '0;
            r_cnt       <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_cnt   <= n_cnt;
            if (r_state == ST_ADD) begin
                r_vld[r_row] <= '1;
            end else if (o_pop && cmd.mode == MODE_PRELOAD) begin
                r_vld[cmd.row][cmd.col] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a <= cmd.operand;
        end
        if (out_load) begin
            r_out_row  <= r_row;
            r_out_col  <= r_cnt;
            r_out_sum  <= acc_val[r_cnt];
            r_out_last <= (r_cnt == IDX_W'(TILE - 1));
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.out_row = r_out_row;
    assign o_out.out_col = r_out_col;
    assign o_out.sum     = r_out_sum;
    assign o_out.last    = r_out_last;
endmodule
